/* rtl/lbc_pkg.sv */
// Shared constants and codes for the line image border clip block.
package lbc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int NUM_BORDERS    = 4;
  localparam int CFG_ADDR_BITS  = 1;
  localparam int QUEUE_DEPTH    = 4;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Border lanes in visiting order.
  localparam int B_LEFT   = 0;
  localparam int B_TOP    = 1;
  localparam int B_RIGHT  = 2;
  localparam int B_BOTTOM = 3;

endpackage

/* rtl/lbc_front.sv */
// Front end: border numerators, sign normalization and exact range tests.
module lbc_front import lbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = COORD_BITS + 1,
  localparam int DB = 2 * CW,
  localparam int LW = 1 + CW + DB
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [CW-1:0]        coef_a,
  input  logic signed [CW-1:0]        coef_b,
  input  logic signed [DB-1:0]        coef_c,
  input  logic [CW-1:0]               width,
  input  logic [CW-1:0]               height,
  output logic                        push,
  output logic [NUM_BORDERS*LW-1:0]   entry
);

  localparam int NW = DB + 2;

  logic                  v1_r, v2_r, v3_r;
  logic signed [CW-1:0]  a1_r, b1_r;
  logic signed [DB-1:0]  c1_r;
  logic signed [DB:0]    pa1_r, pb1_r;
  logic signed [CW:0]    wm1, hm1;

  logic signed [NW-1:0]  n2 [NUM_BORDERS];
  logic signed [CW-1:0]  d2 [NUM_BORDERS];
  logic signed [NW-1:0]  nn2_r [NUM_BORDERS];
  logic [CW-1:0]         dm2_r [NUM_BORDERS];
  logic signed [NW-1:0]  nn3_r [NUM_BORDERS];
  logic [CW-1:0]         dm3_r [NUM_BORDERS];
  logic [DB-1:0]         prod3_r [NUM_BORDERS];
  logic [CW-1:0]         lim [NUM_BORDERS];

  assign wm1 = $signed({1'b0, width}) - $signed((CW+1)'(1));
  assign hm1 = $signed({1'b0, height}) - $signed((CW+1)'(1));

  assign lim[B_LEFT]   = height;
  assign lim[B_TOP]    = width;
  assign lim[B_RIGHT]  = height;
  assign lim[B_BOTTOM] = width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= coef_a;
      b1_r  <= coef_b;
      c1_r  <= coef_c;
      pa1_r <= (DB+1)'(coef_a) * (DB+1)'(wm1);
      pb1_r <= (DB+1)'(coef_b) * (DB+1)'(hm1);
    end
  end

  always_comb begin
    n2[B_LEFT]   = -NW'(c1_r);
    n2[B_TOP]    = -NW'(c1_r);
    n2[B_RIGHT]  = -(NW'(c1_r) + NW'(pa1_r));
    n2[B_BOTTOM] = -(NW'(c1_r) + NW'(pb1_r));
    d2[B_LEFT]   = b1_r;
    d2[B_TOP]    = a1_r;
    d2[B_RIGHT]  = b1_r;
    d2[B_BOTTOM] = a1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_BORDERS; i++) begin
        nn2_r[i]   <= d2[i][CW-1] ? -n2[i] : n2[i];
        dm2_r[i]   <= d2[i][CW-1] ? (~d2[i] + CW'(1)) : d2[i];
        nn3_r[i]   <= nn2_r[i];
        dm3_r[i]   <= dm2_r[i];
        prod3_r[i] <= DB'(lim[i]) * DB'(dm2_r[i]);
      end
    end
  end

  always_comb begin
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_BORDERS; i++) begin
      hit = (dm3_r[i] != '0) && !nn3_r[i][NW-1] &&
            ($unsigned(nn3_r[i]) < {2'b00, prod3_r[i]});
      entry[i*LW +: LW] = {hit, dm3_r[i], nn3_r[i][DB-1:0]};
    end
  end

  assign push = en && v3_r;

endmodule

/* rtl/lbc_queue.sv */
// Short FIFO between front and back ends.
module lbc_queue import lbc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [PW:0]      count_r;

  always_ff @(posedge clk) begin
    if (push) mem[wptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      if (pop)  rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      if (push && !pop)      count_r <= count_r + (PW+1)'(1);
      else if (pop && !push) count_r <= count_r - (PW+1)'(1);
    end
  end

  assign rdata = mem[rptr_r];
  assign full  = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);

endmodule

/* rtl/lbc_back.sv */
// Back end: four pipelined restoring dividers and endpoint selection.
module lbc_back import lbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = COORD_BITS + 1,
  localparam int DB = 2 * CW,
  localparam int LW = 1 + CW + DB
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      take,
  input  logic [NUM_BORDERS*LW-1:0] entry,
  input  logic [CW-1:0]             width,
  input  logic [CW-1:0]             height,
  output logic                      res_valid,
  output logic                      res_found,
  output logic [CW-1:0]             res_sx,
  output logic [CW-1:0]             res_sy,
  output logic [CW-1:0]             res_ex,
  output logic [CW-1:0]             res_ey
);

  localparam int SW = CW + 2;

  logic          v_r   [CW+1];
  logic          hit_r [CW+1][NUM_BORDERS];
  logic [CW-1:0] den_r [CW+1][NUM_BORDERS];
  logic [DB-1:0] rem_r [CW+1][NUM_BORDERS];
  logic [CW-1:0] quo_r [CW+1][NUM_BORDERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= CW; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= take;
      for (int s = 0; s < CW; s++) v_r[s+1] <= v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_BORDERS; i++) begin
        {hit_r[0][i], den_r[0][i], rem_r[0][i]} <= entry[i*LW +: LW];
        quo_r[0][i] <= '0;
      end
    end
  end

  for (genvar s = 0; s < CW; s++) begin : g_div
    localparam int BIT = CW - 1 - s;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < NUM_BORDERS; i++) begin
          logic [DB:0] trial;
          trial = {1'b0, rem_r[s][i]} - ((DB+1)'(den_r[s][i]) << BIT);
          hit_r[s+1][i] <= hit_r[s][i];
          den_r[s+1][i] <= den_r[s][i];
          if (!trial[DB]) begin
            rem_r[s+1][i] <= trial[DB-1:0];
            quo_r[s+1][i] <= quo_r[s][i] | (CW'(1) << BIT);
          end else begin
            rem_r[s+1][i] <= rem_r[s][i];
            quo_r[s+1][i] <= quo_r[s][i];
          end
        end
      end
    end
  end

  logic signed [SW-1:0] sx, sy, ex, ey, wm1, hm1;
  logic signed [SW-1:0] q [NUM_BORDERS];
  logic                 f [NUM_BORDERS];
  logic                 found;

  assign wm1 = $signed(SW'(width)) - $signed(SW'(1));
  assign hm1 = $signed(SW'(height)) - $signed(SW'(1));

  always_comb begin
    for (int i = 0; i < NUM_BORDERS; i++) begin
      q[i] = $signed(SW'(quo_r[CW][i]));
      f[i] = rem_r[CW][i] != '0;
    end
    sx = $signed(SW'(width));
    sy = $signed(SW'(height));
    ex = '0;
    ey = '0;
    found = 1'b0;
    if (hit_r[CW][B_LEFT]) begin
      if (sx > 0) begin
        sx = '0;
        sy = q[B_LEFT];
      end
      found = 1'b1;
    end
    if (hit_r[CW][B_TOP]) begin
      if (q[B_TOP] < sx) begin
        sx = q[B_TOP];
        sy = '0;
      end
      if (q[B_TOP] > ex || (q[B_TOP] == ex && f[B_TOP])) begin
        ex = q[B_TOP];
        ey = '0;
      end
      found = 1'b1;
    end
    if (hit_r[CW][B_RIGHT]) begin
      if (wm1 > ex) begin
        ex = wm1;
        ey = q[B_RIGHT];
      end
      found = 1'b1;
    end
    if (hit_r[CW][B_BOTTOM]) begin
      if (q[B_BOTTOM] < sx) begin
        sx = q[B_BOTTOM];
        sy = hm1;
      end
      if (q[B_BOTTOM] > ex || (q[B_BOTTOM] == ex && f[B_BOTTOM])) begin
        ex = q[B_BOTTOM];
        ey = hm1;
      end
      found = 1'b1;
    end
  end

  logic          res_valid_r, res_found_r;
  logic [CW-1:0] res_sx_r, res_sy_r, res_ex_r, res_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (en) begin
      res_valid_r <= v_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_found_r <= found;
      res_sx_r    <= sx[CW-1:0];
      res_sy_r    <= sy[CW-1:0];
      res_ex_r    <= ex[CW-1:0];
      res_ey_r    <= ey[CW-1:0];
    end
  end

  assign res_valid = res_valid_r;
  assign res_found = res_found_r;
  assign res_sx    = res_sx_r;
  assign res_sy    = res_sy_r;
  assign res_ex    = res_ex_r;
  assign res_ey    = res_ey_r;

endmodule

/* rtl/line_image_border_clip.sv */
// Top level of the line image border clip block.
// Takes one line a*x+b*y+c=0 per cycle while in_tready is high and returns
// one result per line: a found flag and the leftmost and rightmost border
// crossings inside the image. A line passes 3 front stages for the products,
// sign handling and range tests, one queue slot, a divider input register,
// COORD_BITS+1 divider stages and the output register; throughput is one line
// per cycle while the output is taken. Width and height must be written through
// the cfg port only while the block is idle; the block does not enforce this.
module line_image_border_clip import lbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = COORD_BITS + 1,
  localparam int DB = 2 * CW,
  localparam int LW = 1 + CW + DB,
  localparam int TW = ((4 * CW + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CW-1:0]            cfg_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [TW-1:0]            in_tdata,   // coef_a, coef_b, coef_c, zero pad
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [TW-1:0]            out_tdata,  // start_x, start_y, end_x, end_y, zero pad
  output logic                     out_tuser   // found
);

  logic [CW-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(WIDTH_RESET);
      height_r <= CW'(HEIGHT_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                      front_en, back_en, q_push, q_pop, q_full, q_empty;
  logic [NUM_BORDERS*LW-1:0] q_wdata, q_rdata;
  logic                      found;
  logic [CW-1:0]             sx, sy, ex, ey;

  assign back_en   = !out_tvalid || out_tready;
  assign q_pop     = back_en && !q_empty;
  assign front_en  = !q_full || q_pop;
  assign in_tready = front_en;

  lbc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (front_en),
    .in_valid (in_tvalid),
    .coef_a   ($signed(in_tdata[CW-1:0])),
    .coef_b   ($signed(in_tdata[2*CW-1:CW])),
    .coef_c   ($signed(in_tdata[4*CW-1:2*CW])),
    .width    (width_r),
    .height   (height_r),
    .push     (q_push),
    .entry    (q_wdata)
  );

  lbc_queue #(.WIDTH(NUM_BORDERS * LW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  lbc_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (back_en),
    .take      (q_pop),
    .entry     (q_rdata),
    .width     (width_r),
    .height    (height_r),
    .res_valid (out_tvalid),
    .res_found (found),
    .res_sx    (sx),
    .res_sy    (sy),
    .res_ex    (ex),
    .res_ey    (ey)
  );

  assign out_tuser = found;
  assign out_tdata = TW'({ey, ex, sy, sx});

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full || q_pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (ex == '0 && ey == '0))
    else $error("end point set without any hit");

endmodule
